// File: src/mdf_pkg.sv
// Shared types and constants for the magic-word length-prefixed deframer.
package mdf_pkg;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_RESYNC  = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    EV_DATA      = 2'd0,
    EV_ACCEPT    = 2'd1,
    EV_BAD_MAGIC = 2'd2,
    EV_TOO_LONG  = 2'd3
  } event_t;

  localparam logic CFG_MAGIC   = 1'b0;
  localparam logic CFG_MAX_LEN = 1'b1;

  localparam logic [31:0] MAX_LEN_RESET = 32'd1000000;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  // One result word: value holds the data byte for payload events,
  // the decoded length for header events.
  typedef struct packed {
    event_t      kind;
    logic [31:0] value;
    logic        last;
  } rec_t;

  typedef struct packed {
    logic valid;
    rec_t rec;
  } push_t;

endpackage

// File: src/mdf_front.sv
// Front end: takes input words, tracks header, payload and resync phases, and classifies.
module mdf_front #(
  parameter int HEADER_BYTES = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic [7:0]          rx_byte,
  input  logic [31:0]         magic_word,
  input  logic [31:0]         max_length,
  output mdf_pkg::push_t      push
);

  localparam int FILL_W = $clog2(HEADER_BYTES);

  logic [7:0]        window    [HEADER_BYTES];
  logic [7:0]        win_shift [HEADER_BYTES];
  mdf_pkg::phase_t   phase, phase_next;
  logic [FILL_W-1:0] fill, fill_next;
  logic [31:0]       remaining, remaining_next;
  logic [31:0]       seen_magic, seen_len;
  logic              judge;

  // Window as it stands once the incoming word is shifted in.
  always_comb begin
    for (int i = 0; i < HEADER_BYTES - 1; i++) begin
      win_shift[i] = window[i + 1];
    end
    win_shift[HEADER_BYTES - 1] = rx_byte;
  end

  assign seen_magic = {win_shift[0], win_shift[1], win_shift[2], win_shift[3]};
  assign seen_len   = {win_shift[4], win_shift[5], win_shift[6], win_shift[7]};

  always_ff @(posedge clk) begin
    if (take && phase != mdf_pkg::PH_PAYLOAD) begin
      window <= win_shift;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= mdf_pkg::PH_HEADER;
      fill      <= '0;
      remaining <= '0;
    end else begin
      phase     <= phase_next;
      fill      <= fill_next;
      remaining <= remaining_next;
    end
  end

  always_comb begin
    phase_next     = phase;
    fill_next      = fill;
    remaining_next = remaining;
    push           = '0;
    judge          = 1'b0;
    if (take) begin
      unique case (phase)
        mdf_pkg::PH_PAYLOAD: begin
          push.valid     = 1'b1;
          push.rec.kind  = mdf_pkg::EV_DATA;
          push.rec.value = {24'd0, rx_byte};
          push.rec.last  = (remaining <= 32'd1);
          if (remaining <= 32'd1) begin
            phase_next     = mdf_pkg::PH_HEADER;
            fill_next      = '0;
            remaining_next = '0;
          end else begin
            remaining_next = remaining - 32'd1;
          end
        end
        mdf_pkg::PH_RESYNC: begin
          judge = (seen_magic == magic_word);
        end
        default: begin
          // header collecting, also the spare phase code
          phase_next = mdf_pkg::PH_HEADER;
          if (fill == FILL_W'(HEADER_BYTES - 1)) begin
            fill_next = '0;
            judge     = 1'b1;
          end else begin
            fill_next = fill + 1'b1;
          end
        end
      endcase
    end

    if (judge) begin
      push.valid     = 1'b1;
      push.rec.value = seen_len;
      push.rec.last  = 1'b0;
      if (seen_magic != magic_word) begin
        push.rec.kind = mdf_pkg::EV_BAD_MAGIC;
        phase_next    = mdf_pkg::PH_RESYNC;
      end else if (seen_len > max_length) begin
        push.rec.kind = mdf_pkg::EV_TOO_LONG;
        phase_next    = mdf_pkg::PH_RESYNC;
      end else begin
        push.rec.kind = mdf_pkg::EV_ACCEPT;
        fill_next     = '0;
        if (seen_len == 32'd0) begin
          phase_next = mdf_pkg::PH_HEADER;
        end else begin
          phase_next     = mdf_pkg::PH_PAYLOAD;
          remaining_next = seen_len;
        end
      end
    end
  end

endmodule

// File: src/mdf_queue.sv
// Short result queue between the front end and the output stage.
module mdf_queue (
  input  logic           clk,
  input  logic           rst,
  input  mdf_pkg::push_t push,
  input  logic           pop,
  output logic           full,
  output logic           head_valid,
  output mdf_pkg::rec_t  head
);

  localparam int CNT_W = mdf_pkg::QPTR_W + 1;

  mdf_pkg::rec_t              slots [mdf_pkg::QUEUE_DEPTH];
  logic [mdf_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0]           count;
  logic                       do_pop;

  assign full       = (count == CNT_W'(mdf_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push.valid) begin
      slots[wr_ptr] <= push.rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(push.valid) - CNT_W'(do_pop);
    end
  end

endmodule

// File: src/mdf_back.sv
// Output stage: expands queued results into the result fields and drives the handshake.
module mdf_back (
  input  logic          head_valid,
  input  mdf_pkg::rec_t head,
  input  logic          out_ready,
  output logic          out_valid,
  output logic [1:0]    event_kind,
  output logic [7:0]    data_byte,
  output logic [31:0]   frame_length,
  output logic          last_byte,
  output logic          pop
);

  logic is_data;

  assign is_data      = (head.kind == mdf_pkg::EV_DATA);
  assign out_valid    = head_valid;
  assign event_kind   = head.kind;
  assign data_byte    = is_data ? head.value[7:0] : 8'd0;
  assign frame_length = is_data ? 32'd0 : head.value;
  assign last_byte    = is_data && head.last;
  assign pop          = head_valid && out_ready;

endmodule

// File: src/magic_sync_length_deframer_unit.sv
// Top level of the magic-word length-prefixed deframer.
// Usage:
//   Input channel (in_valid/in_ready, rx_byte) takes one link word per clock while in_ready is high.
//   Output channel (out_valid/out_ready) gives at most one result per input word:
//   a payload word (event_kind 0, last_byte on the final one), or a header
//   verdict (accepted, bad magic, length too large) with frame_length.
//   cfg_we/cfg_index/cfg_data write magic_word (index 0) and
//   max_length (index 1); write only while the block is idle.
// Timing: a result is written into the queue at the edge that takes its input
//   word and shows on the output once any results queued ahead of it are taken;
//   the front end has no register stage of its own.
// Throughput: one word per clock while the queue is not full, set by the front
//   end that shifts the header window and judges it in the same cycle.
// Stall: a four-entry result queue parts the two sides; in_ready drops only
//   when the queue is full, and rises again as results are taken.
// Reset: rst clears phase, counters and the queue; no clearing pass. The
//   register values return to magic 0 and maximum length 1000000.
module magic_sync_length_deframer_unit #(
  parameter int HEADER_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  event_kind,
  output logic [7:0]  data_byte,
  output logic [31:0] frame_length,
  output logic        last_byte,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  logic [31:0]    magic_word, max_length;
  logic           take, full, head_valid, pop;
  mdf_pkg::push_t push;
  mdf_pkg::rec_t  head;

  always_ff @(posedge clk) begin
    if (rst) begin
      magic_word <= '0;
      max_length <= mdf_pkg::MAX_LEN_RESET;
    end else if (cfg_we) begin
      if (cfg_index == mdf_pkg::CFG_MAGIC) begin
        magic_word <= cfg_data;
      end
      if (cfg_index == mdf_pkg::CFG_MAX_LEN) begin
        max_length <= cfg_data;
      end
    end
  end

  assign in_ready = !full;
  assign take     = in_valid && in_ready;

  mdf_front #(
    .HEADER_BYTES(HEADER_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .rx_byte   (rx_byte),
    .magic_word(magic_word),
    .max_length(max_length),
    .push      (push)
  );

  mdf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (pop),
    .full      (full),
    .head_valid(head_valid),
    .head      (head)
  );

  mdf_back u_back (
    .head_valid  (head_valid),
    .head        (head),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .event_kind  (event_kind),
    .data_byte   (data_byte),
    .frame_length(frame_length),
    .last_byte   (last_byte),
    .pop         (pop)
  );

`ifndef SYNTHESIS
  a_push_needs_take: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> (in_valid && in_ready))
    else $error("result pushed without an accepted input word");

  a_header_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_kind != mdf_pkg::EV_DATA) |-> (data_byte == 8'd0 && !last_byte))
    else $error("header event carries payload fields");

  a_quiet_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid straight after reset");
`endif

endmodule
